>>> rtl/kcw_pkg.sv
`timescale 1ns / 1ps

package kcw_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int MAX_LEN    = 64;
  localparam int ADDR_W     = $clog2(MAX_LEN);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int K_W        = 7;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [DATA_WIDTH-1:0] data_t;

  typedef struct packed {
    logic signed [DATA_WIDTH:0] diff;
    logic [DATA_WIDTH:0]        mag;
    logic                       neg;
    logic                       zero;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT_RD,
    ST_INIT_DIST,
    ST_LOOP,
    ST_DIST,
    ST_CMP,
    ST_WINIT,
    ST_WCHK,
    ST_WRDL,
    ST_WRDR,
    ST_WCMP,
    ST_ORD,
    ST_OLD,
    ST_EOUT
  } state_t;

endpackage

>>> rtl/kcw_store.sv
`timescale 1ns / 1ps

module kcw_store import kcw_pkg::*; (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  data_t             wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output data_t             rd_data
);

  data_t mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/kcw_alu.sv
`timescale 1ns / 1ps

module kcw_alu import kcw_pkg::*; (
  input  data_t    a,
  input  data_t    b,
  output alu_res_t res
);

  logic signed [DATA_WIDTH:0] diff;

  assign diff = {a[DATA_WIDTH-1], a} - {b[DATA_WIDTH-1], b};

  // difference of two words never reaches -2^DATA_WIDTH, so the magnitude fits
  always_comb begin
    res.diff = diff;
    res.neg  = diff[DATA_WIDTH];
    res.zero = (diff == '0);
    res.mag  = diff[DATA_WIDTH] ? (~diff + 1'b1) : diff;
  end

endmodule

>>> rtl/k_closest_sorted_window_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | operation, start_new, element, target, count_k
// out     | output    | out_valid/out_ready| value, position, is_last, empty_error
//
// a load word is written while idle. a query fetches element 0, then runs binary search
// steps (at most log2(MAX_LEN)+1, plus a final check when the range runs empty), then
// widens the window one step at a time, reading both neighbours unless it sits at an
// array edge, then reads out the result words one at a time.
// the single read port of the element store and the one shared subtractor set this
// pacing. in_ready is high only between queries; result stalls hold the sequencer.
// rst clears the length and the control state; the store itself is not cleared.

module k_closest_sorted_window_top import kcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic                  start_new,
  input  data_t                 element,
  input  data_t                 target,
  input  logic [K_W-1:0]        count_k,
  output logic                  out_valid,
  input  logic                  out_ready,
  output data_t                 value,
  output logic [ADDR_W-1:0]     position,
  output logic                  is_last,
  output logic                  empty_error
);

  state_t state, state_next;

  logic [LEN_W-1:0]  len, len_next;
  data_t             x, x_next;
  logic [ADDR_W-1:0] steps, steps_next;
  logic [ADDR_W-1:0] last, last_next;
  logic [LEN_W-1:0]  lo, lo_next;
  logic [ADDR_W-1:0] hi, hi_next;
  data_t             best_val, best_val_next;
  logic [DATA_WIDTH:0] best_dist, best_dist_next;
  logic [ADDR_W-1:0] best_idx, best_idx_next;
  data_t             v, v_next;
  logic [DATA_WIDTH:0] dc, dc_next;
  logic              vlt, vlt_next;
  logic              veq, veq_next;
  logic signed [DATA_WIDTH:0] dl, dl_next;
  logic [ADDR_W-1:0] left, left_next;
  logic [ADDR_W-1:0] right, right_next;
  logic [ADDR_W-1:0] p, p_next;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  data_t             rd_data;

  data_t             alu_a, alu_b;
  alu_res_t          alu_res;

  logic [LEN_W-1:0]  lohi_sum;
  logic [ADDR_W-1:0] mid;
  logic [LEN_W-1:0]  kc;
  logic              out_free;
  logic              out_load;
  data_t             out_value_d;
  logic [ADDR_W-1:0] out_pos_d;
  logic              out_last_d;
  logic              out_err_d;
  logic              better;

  kcw_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (element),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kcw_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  assign lohi_sum = lo + LEN_W'(hi);
  assign mid      = lohi_sum[LEN_W-1:1];
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  always_comb begin
    if (count_k == '0) begin
      kc = LEN_W'(1);
    end else if (count_k > len) begin
      kc = len;
    end else begin
      kc = LEN_W'(count_k);
    end
  end

  // shared subtractor operand select
  always_comb begin
    case (state)
      ST_CMP: begin
        alu_a = v;
        alu_b = best_val;
      end
      ST_WRDR: begin
        alu_a = x;
        alu_b = rd_data;
      end
      default: begin
        alu_a = rd_data;
        alu_b = x;
      end
    endcase
  end

  assign better = (dc < best_dist) || ((dc == best_dist) && alu_res.neg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      len   <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    x         <= x_next;
    steps     <= steps_next;
    last      <= last_next;
    lo        <= lo_next;
    hi        <= hi_next;
    best_val  <= best_val_next;
    best_dist <= best_dist_next;
    best_idx  <= best_idx_next;
    v         <= v_next;
    dc        <= dc_next;
    vlt       <= vlt_next;
    veq       <= veq_next;
    dl        <= dl_next;
    left      <= left_next;
    right     <= right_next;
    p         <= p_next;
  end

  always_comb begin
    state_next     = state;
    len_next       = len;
    x_next         = x;
    steps_next     = steps;
    last_next      = last;
    lo_next        = lo;
    hi_next        = hi;
    best_val_next  = best_val;
    best_dist_next = best_dist;
    best_idx_next  = best_idx;
    v_next         = v;
    dc_next        = dc;
    vlt_next       = vlt;
    veq_next       = veq;
    dl_next        = dl;
    left_next      = left;
    right_next     = right;
    p_next         = p;
    wr_en          = 1'b0;
    wr_addr        = len[ADDR_W-1:0];
    rd_en          = 1'b0;
    rd_addr        = mid;
    out_load       = 1'b0;
    out_value_d    = rd_data;
    out_pos_d      = p;
    out_last_d     = (p == right);
    out_err_d      = 1'b0;

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (operation == OP_LOAD) begin
            if (start_new) begin
              wr_en    = 1'b1;
              wr_addr  = '0;
              len_next = LEN_W'(1);
            end else if (len < LEN_W'(MAX_LEN)) begin
              wr_en    = 1'b1;
              len_next = len + LEN_W'(1);
            end
          end else if (len == '0) begin
            state_next = ST_EOUT;
          end else begin
            x_next        = target;
            steps_next    = ADDR_W'(kc - LEN_W'(1));
            last_next     = ADDR_W'(len - LEN_W'(1));
            lo_next       = '0;
            hi_next       = ADDR_W'(len - LEN_W'(1));
            best_idx_next = '0;
            state_next    = ST_INIT_RD;
          end
        end
      end
      ST_INIT_RD: begin
        rd_en      = 1'b1;
        rd_addr    = '0;
        state_next = ST_INIT_DIST;
      end
      ST_INIT_DIST: begin
        best_val_next  = rd_data;
        best_dist_next = alu_res.mag;
        state_next     = ST_LOOP;
      end
      ST_LOOP: begin
        if (lo <= LEN_W'(hi)) begin
          rd_en      = 1'b1;
          state_next = ST_DIST;
        end else begin
          state_next = ST_WINIT;
        end
      end
      ST_DIST: begin
        v_next     = rd_data;
        dc_next    = alu_res.mag;
        vlt_next   = alu_res.neg;
        veq_next   = alu_res.zero;
        state_next = ST_CMP;
      end
      ST_CMP: begin
        // tie on distance goes to the smaller word
        if (better) begin
          best_val_next  = v;
          best_dist_next = dc;
          best_idx_next  = mid;
        end
        if (vlt) begin
          lo_next    = LEN_W'(mid) + LEN_W'(1);
          state_next = ST_LOOP;
        end else if (veq || (mid == '0)) begin
          state_next = ST_WINIT;
        end else begin
          hi_next    = mid - ADDR_W'(1);
          state_next = ST_LOOP;
        end
      end
      ST_WINIT: begin
        left_next  = best_idx;
        right_next = best_idx;
        state_next = ST_WCHK;
      end
      ST_WCHK: begin
        if (steps == '0) begin
          p_next     = left;
          state_next = ST_ORD;
        end else if (left == '0) begin
          right_next = right + ADDR_W'(1);
          steps_next = steps - ADDR_W'(1);
        end else if (right == last) begin
          left_next  = left - ADDR_W'(1);
          steps_next = steps - ADDR_W'(1);
        end else begin
          state_next = ST_WRDL;
        end
      end
      ST_WRDL: begin
        rd_en      = 1'b1;
        rd_addr    = left - ADDR_W'(1);
        state_next = ST_WRDR;
      end
      ST_WRDR: begin
        // rd_data holds the left neighbour here
        rd_en      = 1'b1;
        rd_addr    = right + ADDR_W'(1);
        dl_next    = alu_res.diff;
        state_next = ST_WCMP;
      end
      ST_WCMP: begin
        if (dl <= alu_res.diff) begin
          left_next = left - ADDR_W'(1);
        end else begin
          right_next = right + ADDR_W'(1);
        end
        steps_next = steps - ADDR_W'(1);
        state_next = ST_WCHK;
      end
      ST_ORD: begin
        rd_en      = 1'b1;
        rd_addr    = p;
        state_next = ST_OLD;
      end
      ST_OLD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (p == right) begin
            state_next = ST_IDLE;
          end else begin
            p_next     = p + ADDR_W'(1);
            state_next = ST_ORD;
          end
        end
      end
      ST_EOUT: begin
        out_value_d = '0;
        out_pos_d   = '0;
        out_last_d  = 1'b1;
        out_err_d   = 1'b1;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value       <= out_value_d;
      position    <= out_pos_d;
      is_last     <= out_last_d;
      empty_error <= out_err_d;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_LEN))
    else $error("stored length above store size");

  a_window_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WCHK) |-> (left <= right) && (right <= last))
    else $error("window edges out of order");

  a_err_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_error) |-> (is_last && (position == '0) && (value == '0)))
    else $error("bad empty error word");

  a_query_quiet: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_QUERY) && (len != '0)) |=> !out_load)
    else $error("result word loaded right after query start");

endmodule

>>> bench/k_closest_sorted_window_top_tb.sv
`timescale 1ns / 1ps

module k_closest_sorted_window_top_tb import kcw_pkg::*; ;

  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct {
    data_t             value;
    logic [ADDR_W-1:0] position;
    logic              is_last;
    logic              empty_error;
  } window_word_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              operation;
  logic              start_new;
  data_t             element;
  data_t             target;
  logic [K_W-1:0]    count_k;
  logic              out_valid;
  logic              out_ready;
  data_t             value;
  logic [ADDR_W-1:0] position;
  logic              is_last;
  logic              empty_error;

  // shadow copy of the loaded array, sign extended
  longint       shadow_store [MAX_LEN];
  int           shadow_len;
  window_word_t window_queue [$];
  window_word_t head_word;
  data_t        load_vals [MAX_LEN];
  int           mismatch_count;
  int           src_idle_pct;
  int           snk_idle_pct;
  int           cycle_count;

  k_closest_sorted_window_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .start_new  (start_new),
    .element    (element),
    .target     (target),
    .count_k    (count_k),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .position   (position),
    .is_last    (is_last),
    .empty_error(empty_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still pending", $time, window_queue.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  function automatic longint abs64(input longint a);
    return (a < 0) ? -a : a;
  endfunction

  function automatic void predict_load(input logic sn, input data_t el);
    if (sn)
      shadow_len = 0;
    if (shadow_len < MAX_LEN) begin
      shadow_store[shadow_len] = el;
      shadow_len++;
    end
  endfunction

  function automatic void predict_window(input data_t tgt, input logic [K_W-1:0] kin);
    longint       x;
    longint       best_val;
    longint       v;
    int           lo;
    int           hi;
    int           mid;
    int           best_idx;
    int           left;
    int           right;
    int           last_idx;
    int           k;
    window_word_t w;
    if (shadow_len == 0) begin
      w.value       = '0;
      w.position    = '0;
      w.is_last     = 1'b1;
      w.empty_error = 1'b1;
      window_queue.push_back(w);
      return;
    end
    x = tgt;
    k = kin;
    if (k == 0)
      k = 1;
    if (k > shadow_len)
      k = shadow_len;
    // nearest element, ties go to the smaller value
    last_idx = shadow_len - 1;
    lo       = 0;
    hi       = last_idx;
    best_val = shadow_store[0];
    best_idx = 0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      v   = shadow_store[mid];
      if (abs64(v - x) < abs64(best_val - x) ||
          (abs64(v - x) == abs64(best_val - x) && v < best_val)) begin
        best_val = v;
        best_idx = mid;
      end
      if (v < x)
        lo = mid + 1;
      else if (v > x)
        hi = mid - 1;
      else
        lo = hi + 1;
    end
    left  = best_idx;
    right = best_idx;
    for (int i = 1; i < k; i++) begin
      if (left == 0)
        right++;
      else if (right == last_idx ||
               (x - shadow_store[left-1] <= shadow_store[right+1] - x))
        left--;
      else
        right++;
    end
    for (int i = 0; i < k; i++) begin
      w.value       = shadow_store[left+i][31:0];
      w.position    = ADDR_W'(left + i);
      w.is_last     = (i == k - 1);
      w.empty_error = 1'b0;
      window_queue.push_back(w);
    end
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (window_queue.size() == 0) begin
        $display("%0t: unexpected word, expected none, got value %0h position %0d",
                 $time, value, position);
        mismatch_count++;
      end else begin
        head_word = window_queue.pop_front();
        check_field("value", head_word.value, value);
        check_field("position", head_word.position, position);
        check_field("is_last", head_word.is_last, is_last);
        check_field("empty_error", head_word.empty_error, empty_error);
      end
    end
  end

  task automatic send_word(input logic op, input logic sn, input data_t el, input data_t tgt,
                           input logic [K_W-1:0] k);
    @(negedge clk);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < src_idle_pct);
    end
    in_valid  <= 1'b1;
    operation <= op;
    start_new <= sn;
    element   <= el;
    target    <= tgt;
    count_k   <= k;
    do @(posedge clk); while (!in_ready);
    if (op == OP_LOAD)
      predict_load(sn, el);
    else
      predict_window(tgt, k);
  endtask

  // hold the input side until every pending word is out
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (window_queue.size() != 0)
      @(posedge clk);
  endtask

  // mode 0 gives dense values with repeats, mode 1 a narrow spread, else full range
  function automatic void build_array(input int len, input int mode, input bit sorted);
    data_t v;
    int    j;
    for (int i = 0; i < len; i++) begin
      case (mode)
        0:       v = $urandom_range(0, 40) - 20;
        1:       v = $urandom_range(0, 4000) - 2000;
        default: v = $urandom;
      endcase
      j = i;
      if (sorted) begin
        while (j > 0 && load_vals[j-1] > v) begin
          load_vals[j] = load_vals[j-1];
          j--;
        end
      end
      load_vals[j] = v;
    end
  endfunction

  task automatic test_empty_query();
    send_word(OP_QUERY, 1'b1, 32'h1234_5678, 32'h0000_0005, 7'd3);
    send_word(OP_QUERY, 1'b0, 32'h0, 32'h8000_0000, 7'd0);
  endtask

  task automatic test_edge_values();
    send_word(OP_LOAD, 1'b1, 32'h8000_0000, 32'hffff_ffff, 7'd127);
    send_word(OP_LOAD, 1'b0, 32'h8000_0000, 32'h0, 7'd0);
    send_word(OP_LOAD, 1'b0, -32'sd7, 32'h0, 7'd0);
    send_word(OP_LOAD, 1'b0, 32'sd0, 32'h0, 7'd0);
    send_word(OP_LOAD, 1'b0, 32'sd4, 32'h0, 7'd0);
    send_word(OP_LOAD, 1'b0, 32'h7fff_ffff, 32'h0, 7'd0);
    // k of zero at the bottom edge, oversized k at the top edge
    send_word(OP_QUERY, 1'b1, 32'hffff_ffff, 32'h8000_0000, 7'd0);
    send_word(OP_QUERY, 1'b0, 32'h0, 32'h7fff_ffff, 7'd127);
    // equidistant from 0 and 4
    send_word(OP_QUERY, 1'b0, 32'h0, 32'sd2, 7'd2);
    send_word(OP_QUERY, 1'b0, 32'h0, 32'sd0, 7'd1);
    send_word(OP_QUERY, 1'b0, 32'h0, 32'sd100, 7'd64);
  endtask

  task automatic test_unsorted_data();
    send_word(OP_LOAD, 1'b1, 32'sd5, 32'h0, 7'd0);
    send_word(OP_LOAD, 1'b0, -32'sd3, 32'h0, 7'd0);
    send_word(OP_LOAD, 1'b0, 32'sd9, 32'h0, 7'd0);
    send_word(OP_LOAD, 1'b0, 32'sd1, 32'h0, 7'd0);
    send_word(OP_QUERY, 1'b0, 32'h0, 32'sd2, 7'd4);
    send_word(OP_QUERY, 1'b0, 32'h0, -32'sd100, 7'd2);
    // single element array
    send_word(OP_LOAD, 1'b1, 32'sd42, 32'h0, 7'd0);
    send_word(OP_QUERY, 1'b0, 32'h0, 32'sd0, 7'd64);
  endtask

  task automatic test_full_store();
    build_array(MAX_LEN, 2, 1'b1);
    for (int i = 0; i < MAX_LEN; i++)
      send_word(OP_LOAD, i == 0, load_vals[i], $urandom, K_W'($urandom));
    // store is full, these two are dropped
    send_word(OP_LOAD, 1'b0, $urandom, $urandom, K_W'($urandom));
    send_word(OP_LOAD, 1'b0, $urandom, $urandom, K_W'($urandom));
    send_word(OP_QUERY, 1'($urandom), $urandom, $urandom, 7'd64);
    wait_drained();
    send_word(OP_QUERY, 1'($urandom), $urandom, 32'h8000_0000, 7'd127);
    send_word(OP_QUERY, 1'($urandom), $urandom, load_vals[31], 7'd0);
    send_word(OP_QUERY, 1'($urandom), $urandom, 32'h7fff_ffff, 7'd5);
    send_word(OP_QUERY, 1'($urandom), $urandom, load_vals[10], 7'd63);
  endtask

  task automatic test_random_arrays(input int n_items);
    int             sent;
    int             len;
    int             nq;
    int             idx;
    longint         t;
    logic [K_W-1:0] kq;
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      build_array(len, $urandom_range(0, 2), $urandom_range(0, 7) != 0);
      for (int i = 0; i < len; i++)
        send_word(OP_LOAD, i == 0, load_vals[i], $urandom, K_W'($urandom));
      sent += len;
      nq = $urandom_range(1, 4);
      for (int q = 0; q < nq; q++) begin
        idx = $urandom_range(0, len - 1);
        case ($urandom_range(0, 9))
          0, 1: t = data_t'($urandom);
          2:    t = $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
          // midpoint of two neighbors gives distance ties
          3:    t = (idx < len - 1) ? (longint'(load_vals[idx]) + load_vals[idx+1]) / 2
                                    : longint'(load_vals[idx]);
          default: t = longint'(load_vals[idx]) + (int'($urandom_range(0, 6)) - 3);
        endcase
        if (t > 64'sd2147483647)
          t = 64'sd2147483647;
        if (t < -64'sd2147483648)
          t = -64'sd2147483648;
        case ($urandom_range(0, 9))
          0:       kq = K_W'($urandom_range(0, 127));
          1:       kq = $urandom_range(0, 1) ? 7'd64 : 7'd127;
          default: kq = K_W'($urandom_range(0, len + 1));
        endcase
        send_word(OP_QUERY, 1'($urandom), $urandom, t[31:0], kq);
        sent++;
      end
      case ($urandom_range(0, 9))
        // append to the array with no ordering
        0: begin
          send_word(OP_LOAD, 1'b0, $urandom, $urandom, K_W'($urandom));
          send_word(OP_QUERY, 1'($urandom), $urandom, $urandom,
                    K_W'($urandom_range(0, 16)));
          sent += 2;
        end
        1:       wait_drained();
        default: ;
      endcase
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    operation      = OP_LOAD;
    start_new      = 1'b0;
    element        = '0;
    target         = '0;
    count_k        = '0;
    out_ready      = 1'b0;
    shadow_len     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    src_idle_pct   = 24;
    snk_idle_pct   = 74;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_query();
    test_edge_values();
    test_unsorted_data();
    test_full_store();
    test_random_arrays(25);
    wait_drained();

    src_idle_pct = 74;
    snk_idle_pct = 24;
    test_random_arrays(25);
    wait_drained();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_arrays(25);
    wait_drained();
    repeat (20) @(posedge clk);

    if (mismatch_count == 0 && window_queue.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sim.f
rtl/kcw_pkg.sv
rtl/kcw_store.sv
rtl/kcw_alu.sv
rtl/k_closest_sorted_window_top.sv
bench/k_closest_sorted_window_top_tb.sv
